// File: hw/rtl/gcsn_pkg.sv
package gcsn_pkg;

  localparam int GHOSTS     = 2;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_SHIFT = 2 * FRAC_BITS;
  // wide enough for the exact signed product and the integer slice above the shift
  localparam int PROD_W     = PROD_SHIFT + 33;
  localparam int PART_W     = 33 + 17;
  localparam int HALF_W     = 16;

  localparam int QDEPTH = 8;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int NAXES   = 3;
  localparam int STAGES  = 5;
  localparam int ROW_W   = 13;
  localparam int NXY_W   = 2 * ROW_W;

  // register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_RECIP_X  = 3'd3;
  localparam logic [2:0] REG_RECIP_Y  = 3'd4;
  localparam logic [2:0] REG_RECIP_Z  = 3'd5;
  localparam logic [2:0] REG_ROW_X    = 3'd6;
  localparam logic [2:0] REG_ROW_Y    = 3'd7;

  // action codes
  localparam logic [1:0] ACT_CELL    = 2'd0;
  localparam logic [1:0] ACT_CORNERS = 2'd1;
  localparam logic [1:0] ACT_STENCIL = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  typedef struct packed {
    logic [NAXES-1:0][31:0] origin;
    logic [NAXES-1:0][31:0] recip;
    logic [ROW_W-1:0]       nx;
    logic [NXY_W-1:0]       nxy;
  } cfg_t;

  typedef struct packed {
    logic [31:0] base;
    logic [1:0]  action;
  } qentry_t;

endpackage

// File: hw/rtl/gcsn_front.sv
module gcsn_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gcsn_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_action,
  input  logic signed [31:0]     in_pos_x,
  input  logic signed [31:0]     in_pos_y,
  input  logic signed [31:0]     in_pos_z,
  input  logic [gcsn_pkg::QCNT_W-1:0] q_count,
  output logic                   push,
  output gcsn_pkg::qentry_t      push_entry
);
  import gcsn_pkg::*;

  localparam int CRED_W = QCNT_W + 1;

  logic [STAGES-1:0] v_r;
  logic              accept;

  logic [1:0]               act1_r, act2_r, act3_r, act4_r;
  logic signed [32:0]       diff1_r [NAXES];
  logic signed [PART_W-1:0] pl2_r   [NAXES];
  logic signed [PART_W-1:0] ph2_r   [NAXES];
  logic signed [PROD_W-1:0] prod    [NAXES];
  logic [31:0]              coord3_r [NAXES];
  logic [31:0]              i4_r, jnx4_r, knxy4_r;
  qentry_t                  entry5_r;
  logic signed [31:0]       pos [NAXES];
  logic [CRED_W-1:0]        used;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  // every item in flight holds a queue slot, so the pipe itself never stalls
  assign used     = CRED_W'(q_count) + CRED_W'($countones(v_r));
  assign in_stall = used >= CRED_W'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[STAGES-2:0], accept && (in_action != ACT_NONE)};
    end
  end

  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      prod[a] = PROD_W'(pl2_r[a]) + (PROD_W'(ph2_r[a]) <<< HALF_W);
    end
  end

  always_ff @(posedge clk) begin
    act1_r <= in_action;
    act2_r <= act1_r;
    act3_r <= act2_r;
    act4_r <= act3_r;
    for (int a = 0; a < NAXES; a++) begin
      diff1_r[a] <= 33'(pos[a]) - 33'($signed(cfg.origin[a]));
      pl2_r[a]   <= diff1_r[a] * $signed({1'b0, cfg.recip[a][HALF_W-1:0]});
      ph2_r[a]   <= diff1_r[a] * $signed({1'b0, cfg.recip[a][31:HALF_W]});
      // stencil base steps back where the fraction is below one half
      coord3_r[a] <= prod[a][PROD_SHIFT+31:PROD_SHIFT] + 32'(GHOSTS)
                     - {31'b0, (act2_r == ACT_STENCIL) && !prod[a][PROD_SHIFT-1]};
    end
    i4_r    <= coord3_r[0];
    jnx4_r  <= 32'(coord3_r[1] * cfg.nx);
    knxy4_r <= 32'(coord3_r[2] * cfg.nxy);
    entry5_r.base   <= i4_r + jnx4_r + knxy4_r;
    entry5_r.action <= act4_r;
  end

  assign push       = v_r[STAGES-1];
  assign push_entry = entry5_r;

endmodule

// File: hw/rtl/gcsn_queue.sv
module gcsn_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  gcsn_pkg::qentry_t           push_entry,
  input  logic                        pop,
  output gcsn_pkg::qentry_t           head,
  output logic                        empty,
  output logic [gcsn_pkg::QCNT_W-1:0] count
);
  import gcsn_pkg::*;

  qentry_t             mem_r [QDEPTH];
  logic [QIDX_W-1:0]   wr_r, rd_r;
  logic [QCNT_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= QIDX_W'(wr_r + 1'b1);
      end
      if (pop) begin
        rd_r <= QIDX_W'(rd_r + 1'b1);
      end
      cnt_r <= QCNT_W'(cnt_r + QCNT_W'(push) - QCNT_W'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  assign head  = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

// File: hw/rtl/gcsn_back.sv
module gcsn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gcsn_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  gcsn_pkg::qentry_t  q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_node_id,
  output logic [4:0]         out_slot,
  output logic               out_last
);
  import gcsn_pkg::*;

  logic        busy_r;
  logic [31:0] base_r, offy_r, offz_r;
  logic [1:0]  lim_r, dx_r, dy_r, dz_r;
  logic [4:0]  slot_r;
  logic        ovalid_r;
  logic [31:0] oid_r;
  logic [4:0]  oslot_r;
  logic        olast_r;

  logic emit, is_last, load;

  assign emit    = busy_r && (!ovalid_r || !out_stall);
  assign is_last = (dx_r == lim_r) && (dy_r == lim_r) && (dz_r == lim_r);
  assign load    = (!busy_r || (emit && is_last)) && !q_empty;
  assign pop     = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // the action code doubles as the last offset on each axis
  always_ff @(posedge clk) begin
    if (load) begin
      base_r <= q_head.base;
      lim_r  <= q_head.action;
      dx_r   <= '0;
      dy_r   <= '0;
      dz_r   <= '0;
      offy_r <= '0;
      offz_r <= '0;
      slot_r <= '0;
    end else if (emit) begin
      slot_r <= 5'(slot_r + 1'b1);
      if (dx_r != lim_r) begin
        dx_r <= 2'(dx_r + 1'b1);
      end else begin
        dx_r <= '0;
        if (dy_r != lim_r) begin
          dy_r   <= 2'(dy_r + 1'b1);
          offy_r <= offy_r + 32'(cfg.nx);
        end else begin
          dy_r   <= '0;
          offy_r <= '0;
          dz_r   <= 2'(dz_r + 1'b1);
          offz_r <= offz_r + 32'(cfg.nxy);
        end
      end
    end
    if (emit) begin
      oid_r   <= base_r + 32'(dx_r) + offy_r + offz_r;
      oslot_r <= slot_r;
      olast_r <= is_last;
    end
  end

  assign out_valid   = ovalid_r;
  assign out_node_id = $signed(oid_r);
  assign out_slot    = oslot_r;
  assign out_last    = olast_r;

endmodule

// File: hw/rtl/grid_cell_and_stencil_node_index_unit.sv
// Maps a particle position to grid ids. Each accepted transaction gives one cell id
// (action 0), the 8 corner node ids (action 1) or the 27 stencil node ids (action 2),
// one id per cycle while out_stall is low, on the result channel with its slot number
// and a last flag; action 3 is taken and dropped. Grid coordinates are (pos - origin)
// * recip_size + 2 per axis, floored, less one for a stencil where the fraction is
// below one half; ids wrap at 32 bits. A new transaction can be taken every cycle
// while in_stall is low; the sustained rate is set by the id sequencer at the output
// and the action. A 5-stage coordinate pipe feeds an 8-entry queue ahead of it. The
// user must write registers only while the unit is idle; nothing here enforces it.
module grid_cell_and_stencil_node_index_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_node_id,
  output logic [4:0]         out_slot,
  output logic               out_last
);
  import gcsn_pkg::*;

  logic [NAXES-1:0][31:0] origin_r, recip_r;
  logic [ROW_W-1:0]       nx_r, ny_r;
  logic [NXY_W-1:0]       nxy_r;
  cfg_t                   cfg;

  logic               push, pop, q_empty;
  qentry_t            push_entry, q_head;
  logic [QCNT_W-1:0]  q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      recip_r  <= {NAXES{32'd65536}};
      nx_r     <= ROW_W'(1);
      ny_r     <= ROW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_r[0] <= cfg_wdata;
        REG_ORIGIN_Y: origin_r[1] <= cfg_wdata;
        REG_ORIGIN_Z: origin_r[2] <= cfg_wdata;
        REG_RECIP_X:  recip_r[0]  <= cfg_wdata;
        REG_RECIP_Y:  recip_r[1]  <= cfg_wdata;
        REG_RECIP_Z:  recip_r[2]  <= cfg_wdata;
        REG_ROW_X:    nx_r        <= cfg_wdata[ROW_W-1:0];
        REG_ROW_Y:    ny_r        <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // plane size is registered from the row sizes, well before any item needs it
  always_ff @(posedge clk) begin
    nxy_r <= nx_r * ny_r;
  end

  assign cfg.origin = origin_r;
  assign cfg.recip  = recip_r;
  assign cfg.nx     = nx_r;
  assign cfg.nxy    = nxy_r;

  gcsn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  gcsn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .empty      (q_empty),
    .count      (q_count)
  );

  gcsn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_node_id (out_node_id),
    .out_slot    (out_slot),
    .out_last    (out_last)
  );

endmodule
